FILE: rtl/core/ievf_pkg.sv
// shared types and constants for the include/exclude value filter
// no dependencies; used by the top level and its checker

package ievf_pkg;

  // width of every value field and of the compared value
  localparam int unsigned VALUE_WIDTH = 16;

  // number of field kinds that take part in a check
  localparam int unsigned KIND_COUNT = 3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_CHECK  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TRIAL  = 2'd0,
    KIND_ERROR  = 2'd1,
    KIND_COND   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    op_e                            opcode;
    kind_e                          entry_kind;
    logic                           entry_include;
    logic signed [VALUE_WIDTH-1:0]  entry_value;
    logic signed [VALUE_WIDTH-1:0]  trial_number;
    logic signed [VALUE_WIDTH-1:0]  error_value;
    logic signed [VALUE_WIDTH-1:0]  condition_value;
  } req_t;

  typedef struct packed {
    logic passed;
    logic status;
  } rsp_t;

  typedef struct packed {
    kind_e                   kind;
    logic                    incl;
    logic [VALUE_WIDTH-1:0]  value;
  } entry_t;

  // per-kind match flags gathered during a table walk
  typedef struct packed {
    logic [KIND_COUNT-1:0] has_inc;
    logic [KIND_COUNT-1:0] hit_inc;
    logic                  excluded;
  } flags_t;

endpackage

FILE: rtl/core/include_exclude_value_filter_top.sv
// include/exclude value filter: entry table in one synchronous memory
// depends on ievf_pkg

// The block holds a table of up to TABLE_ENTRIES filter entries, each a
// field kind, an include/exclude mark and one value. An item is taken at a
// rising edge where start is high and busy is low; every item gives exactly
// one result, shown on rsp_o for a single cycle while done_o is high, and
// the receiver has no way to hold it off, so it must sample rsp_o whenever
// done_o is high. Clear, add and unused opcodes give their result in the
// cycle after the item is taken, and busy stays low, so such items may
// be issued every cycle. A check walks the table through the one read
// port of the entry memory, one entry per cycle; busy stays high through
// the walk and a final drain state, and the next item can be taken once
// busy falls, which is the cycle in which done_o shows the check result.
// A check on an empty table answers in the cycle after it is taken, like
// the other opcodes. An add into a full table drops the entry and reports
// status 1. Entries are compared on their full value width.
// The memory needs no clearing pass: only entries below the fill count are
// ever read, and every one of those was written since the last clear.

module include_exclude_value_filter_top #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ievf_pkg::req_t req_i,
  output logic           done_o,
  output ievf_pkg::rsp_t rsp_o
);

  // address and fill count widths follow the table depth
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned VW = ievf_pkg::VALUE_WIDTH;
  localparam int unsigned KN = ievf_pkg::KIND_COUNT;

  // entry memory, written on add, read during a check walk
  ievf_pkg::entry_t mem_q [TABLE_ENTRIES];

  ievf_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  logic [AW-1:0]    last_idx_q;
  logic             rvalid_q;
  ievf_pkg::entry_t rdata_q;
  logic [VW-1:0]    rec_q [KN];
  ievf_pkg::flags_t flags_q, flags_d;
  logic             done_q, done_d;
  ievf_pkg::rsp_t   rsp_q, rsp_d;

  logic             accept;
  logic             is_full;
  logic             wr_en;
  logic             rd_en;
  logic             chk_start;
  logic             chk_empty;
  logic             last_rd;
  logic [VW-1:0]    rec_val;
  logic             match;
  logic             passed_final;

  assign accept    = start && !busy;
  assign is_full   = (count_q == CW'(TABLE_ENTRIES));
  assign chk_empty = (count_q == '0);
  assign chk_start = accept && (req_i.opcode == ievf_pkg::OP_CHECK);
  assign wr_en     = accept && (req_i.opcode == ievf_pkg::OP_ADD) && !is_full;
  assign last_rd   = (rd_idx_q == last_idx_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ievf_pkg::ST_IDLE: begin
        if (chk_start && !chk_empty) begin
          state_d = ievf_pkg::ST_WALK;
        end
      end
      ievf_pkg::ST_WALK: begin
        if (last_rd) begin
          state_d = ievf_pkg::ST_DRAIN;
        end
      end
      ievf_pkg::ST_DRAIN: begin
        state_d = ievf_pkg::ST_IDLE;
      end
      default: begin
        state_d = ievf_pkg::ST_IDLE;
      end
    endcase
  end

  // state decoded outputs
  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    unique case (state_q)
      ievf_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      ievf_pkg::ST_WALK: begin
        rd_en = 1'b1;
      end
      ievf_pkg::ST_DRAIN: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // read index steps through the table while walking
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (chk_start) begin
      rd_idx_d = '0;
    end else if (rd_en) begin
      rd_idx_d = rd_idx_q + AW'(1);
    end
  end

  // fill count
  always_comb begin
    count_d = count_q;
    if (accept) begin
      unique case (req_i.opcode)
        ievf_pkg::OP_CLEAR: count_d = '0;
        ievf_pkg::OP_ADD: begin
          if (!is_full) begin
            count_d = count_q + CW'(1);
          end
        end
        default: count_d = count_q;
      endcase
    end
  end

  // record value that the entry in flight is compared against
  always_comb begin
    unique case (rdata_q.kind)
      ievf_pkg::KIND_TRIAL: rec_val = rec_q[0];
      ievf_pkg::KIND_ERROR: rec_val = rec_q[1];
      ievf_pkg::KIND_COND:  rec_val = rec_q[2];
      default:              rec_val = '0;
    endcase
  end

  assign match = (rdata_q.value == rec_val);

  // fold the entry in flight into the match flags; the unused kind never counts
  always_comb begin
    flags_d = flags_q;
    if (chk_start) begin
      flags_d = '0;
    end else if (rvalid_q && (rdata_q.kind != ievf_pkg::KIND_UNUSED)) begin
      if (rdata_q.incl) begin
        flags_d.has_inc[rdata_q.kind] = 1'b1;
        if (match) begin
          flags_d.hit_inc[rdata_q.kind] = 1'b1;
        end
      end else if (match) begin
        flags_d.excluded = 1'b1;
      end
    end
  end

  // fails on any exclude hit or on a kind whose include list missed
  assign passed_final = !flags_d.excluded &&
                        ((flags_d.has_inc & ~flags_d.hit_inc) == '0);

  // result register
  always_comb begin
    done_d = 1'b0;
    rsp_d  = rsp_q;
    if (state_q == ievf_pkg::ST_DRAIN) begin
      done_d       = 1'b1;
      rsp_d.passed = passed_final;
      rsp_d.status = 1'b0;
    end else if (accept) begin
      rsp_d.passed = 1'b0;
      rsp_d.status = 1'b0;
      unique case (req_i.opcode)
        ievf_pkg::OP_CLEAR: done_d = 1'b1;
        ievf_pkg::OP_ADD: begin
          done_d       = 1'b1;
          rsp_d.status = is_full;
        end
        ievf_pkg::OP_CHECK: begin
          // an empty table always passes and answers at once
          done_d       = chk_empty;
          rsp_d.passed = chk_empty;
        end
        default: done_d = 1'b1;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ievf_pkg::ST_IDLE;
      count_q  <= '0;
      rd_idx_q <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      rvalid_q <= rd_en;
      done_q   <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    rsp_q   <= rsp_d;
    if (chk_start) begin
      rec_q[0]   <= req_i.trial_number[VW-1:0];
      rec_q[1]   <= req_i.error_value[VW-1:0];
      rec_q[2]   <= req_i.condition_value[VW-1:0];
      last_idx_q <= AW'(count_q - CW'(1));
    end
  end

  // entry memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= '{kind:  req_i.entry_kind,
                                  incl:  req_i.entry_include,
                                  value: req_i.entry_value[VW-1:0]};
    end
  end

  // entry memory read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: rtl/core/ievf_checker.sv
// port-level checks for the include/exclude value filter, bound to the top
// depends on ievf_pkg and include_exclude_value_filter_top

module ievf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input ievf_pkg::req_t req_i,
  input logic           done_o,
  input ievf_pkg::rsp_t rsp_o
);

  // a result never both passes and reports a dropped entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.passed && rsp_o.status))
    else $error("result passed and flagged full at once");

  // opcodes other than check answer in the next cycle and leave the block free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.opcode != ievf_pkg::OP_CHECK)) |=> (done_o && !busy))
    else $error("one-cycle item gave no result or left the block busy");

  // a table full flag only follows an accepted add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status) |->
      $past(start && !busy && (req_i.opcode == ievf_pkg::OP_ADD)))
    else $error("full flag without a preceding add");

  // the end of a table walk always comes with the check result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (done_o && !rsp_o.status))
    else $error("walk ended without a check result");

endmodule

bind include_exclude_value_filter_top ievf_checker u_ievf_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

FILE: sim/tb_top.sv
// self-checking testbench for the include/exclude value filter
// depends on ievf_pkg and include_exclude_value_filter_top; needs no files or arguments
`timescale 1ns / 1ps

module tb_top;
  import ievf_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  // slowest correct run: under 1800 items, each taking at most a full-table walk
  // plus an idle gap; CYCLE_LIMIT is set above that bound
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  // a check on a full table answers after walking every entry and a drain state
  localparam int unsigned TAIL_CYCLES   = 300;

  // one row of the directed stimulus: an item, how often it is repeated, and
  // optionally a hand-written expected result
  typedef struct packed {
    req_t        req;
    logic [15:0] reps;
    logic        fixed;
    rsp_t        rsp;
  } stim_row_t;

  logic   clk_i;
  logic   rst_ni = 1'b0;
  logic   start  = 1'b0;
  req_t   req_i  = '0;
  logic   busy;
  logic   done_o;
  rsp_t   rsp_o;

  // hand-written expectation travelling with the item on req_i
  logic   cur_fixed     = 1'b0;
  rsp_t   cur_fixed_rsp = '0;

  // shadow copy of the filter table
  logic [1:0]             kept_kind [TABLE_ENTRIES];
  logic                   kept_inc  [TABLE_ENTRIES];
  logic [VALUE_WIDTH-1:0] kept_val  [TABLE_ENTRIES];
  int unsigned            kept_count = 0;

  rsp_t        pending_rsp [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;

  // per-sequence value pool so that checks hit the loaded entries
  logic [VALUE_WIDTH-1:0] value_pool [KIND_COUNT][4];

  include_exclude_value_filter_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_rsp.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // works out the result of one item and updates the shadow table
  function automatic rsp_t judge_item(input req_t r);
    rsp_t                   o;
    logic [KIND_COUNT-1:0]  has_inc;
    logic [KIND_COUNT-1:0]  hit_inc;
    logic                   excluded;
    logic [VALUE_WIDTH-1:0] rec [KIND_COUNT];
    int unsigned            k;
    o        = '0;
    has_inc  = '0;
    hit_inc  = '0;
    excluded = 1'b0;
    case (r.opcode)
      OP_CLEAR: kept_count = 0;
      OP_ADD: begin
        if (kept_count >= TABLE_ENTRIES) begin
          o.status = 1'b1;
        end else begin
          kept_kind[kept_count] = r.entry_kind;
          kept_inc[kept_count]  = r.entry_include;
          kept_val[kept_count]  = r.entry_value;
          kept_count++;
        end
      end
      OP_CHECK: begin
        rec[0] = r.trial_number;
        rec[1] = r.error_value;
        rec[2] = r.condition_value;
        for (int unsigned i = 0; i < kept_count; i++) begin
          k = kept_kind[i];
          // an entry of the fourth kind never takes part
          if (k < KIND_COUNT) begin
            if (kept_inc[i]) begin
              has_inc[k] = 1'b1;
              if (kept_val[i] == rec[k]) hit_inc[k] = 1'b1;
            end else if (kept_val[i] == rec[k]) begin
              excluded = 1'b1;
            end
          end
        end
        o.passed = !excluded && ((has_inc & ~hit_inc) == '0);
      end
      default: ;
    endcase
    return o;
  endfunction

  // result checker and item tracker: results pop the oldest expectation,
  // accepted items push a new one (a result never belongs to an item taken
  // at the same edge, so popping first is safe)
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp.size() == 0) begin
          flag_mismatch($sformatf("result %b/%b with nothing expected",
                                  rsp_o.passed, rsp_o.status));
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o.passed !== want.passed)
            flag_mismatch($sformatf("passed %b, expected %b", rsp_o.passed, want.passed));
          if (rsp_o.status !== want.status)
            flag_mismatch($sformatf("status %b, expected %b", rsp_o.status, want.status));
        end
      end
      if (start && !busy) begin
        want = judge_item(req_i);
        if (cur_fixed) want = cur_fixed_rsp;
        pending_rsp.push_back(want);
      end
    end
  end

  function automatic logic [VALUE_WIDTH-1:0] rand_value();
    return VALUE_WIDTH'($urandom_range(0, (1 << VALUE_WIDTH) - 1));
  endfunction

  function automatic req_t make_req(input logic [1:0] op, input logic [1:0] kind,
                                    input logic inc, input logic [VALUE_WIDTH-1:0] val,
                                    input logic [VALUE_WIDTH-1:0] trial,
                                    input logic [VALUE_WIDTH-1:0] err,
                                    input logic [VALUE_WIDTH-1:0] cond);
    req_t r;
    r.opcode          = op_e'(op);
    r.entry_kind      = kind_e'(kind);
    r.entry_include   = inc;
    r.entry_value     = val;
    r.trial_number    = trial;
    r.error_value     = err;
    r.condition_value = cond;
    return r;
  endfunction

  // one line of the directed table
  task automatic row(input logic [1:0] op, input logic [1:0] kind, input logic inc,
                     input logic [15:0] val, input logic [15:0] trial,
                     input logic [15:0] err, input logic [15:0] cond,
                     input int unsigned reps, input logic fixed,
                     input logic passed, input logic status);
    stim_row_t s;
    s.req        = make_req(op, kind, inc, val, trial, err, cond);
    s.reps       = 16'(reps);
    s.fixed      = fixed;
    s.rsp.passed = passed;
    s.rsp.status = status;
    directed_rows.push_back(s);
  endtask

  // idle cycles before the next item; none in the quiet stretch
  function automatic int unsigned idle_gap();
    int unsigned g;
    g = 0;
    if (sent_count >= 900 && sent_count < 1150) return 0;
    while (g < 8 && $urandom_range(0, 99) < 30) g++;
    return g;
  endfunction

  // raises start with an item and returns at the edge that takes it; start
  // stays high while busy, so items also wait out a table walk
  task automatic issue(input req_t r, input logic fixed, input rsp_t fixed_rsp);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    req_i         <= r;
    cur_fixed     <= fixed;
    cur_fixed_rsp <= fixed_rsp;
    do @(posedge clk_i); while (busy);
    sent_count++;
  endtask

  task automatic drive_checked(input req_t r);
    issue(r, 1'b0, '0);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic pause_until_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pool_value();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return rand_value();
    endcase
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] record_value(input int unsigned k);
    if ($urandom_range(0, 99) < 75) return value_pool[k][$urandom_range(0, 3)];
    return rand_value();
  endfunction

  initial begin
    int unsigned n_add;
    logic [1:0]  kind;
    req_t        r;

    // --- directed table ---
    // empty table always passes
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h7fff, 16'h8000, 16'h0000, 1, 1, 1, 0);
    // unused opcode with every other bit set does nothing
    row(OP_UNUSED, KIND_UNUSED, 1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 1, 0, 0);
    row(OP_CLEAR, KIND_UNUSED, 1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 1, 0, 0);
    // single include on the trial number, most positive value
    row(OP_ADD, KIND_TRIAL, 1, 16'h7fff, 16'hffff, 16'hffff, 16'hffff, 1, 1, 0, 0);
    row(OP_CHECK, KIND_UNUSED, 1, 16'hffff, 16'h7fff, 16'hffff, 16'hffff, 1, 1, 1, 0);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 1, 1, 0, 0);
    // exclude on the error code, most negative value
    row(OP_ADD, KIND_ERROR, 0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h7fff, 16'h8000, 16'h0000, 1, 1, 0, 0);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h7fff, 16'h7fff, 16'h0000, 1, 1, 1, 0);
    // include list of two condition values
    row(OP_ADD, KIND_COND, 1, 16'h0000, 16'h1111, 16'h2222, 16'h3333, 1, 1, 0, 0);
    row(OP_ADD, KIND_COND, 1, 16'hffff, 16'h1111, 16'h2222, 16'h3333, 1, 1, 0, 0);
    row(OP_CHECK, KIND_COND, 1, 16'h5a5a, 16'h7fff, 16'h0001, 16'hffff, 1, 0, 0, 0);
    row(OP_CHECK, KIND_COND, 1, 16'h5a5a, 16'h7fff, 16'h0001, 16'h0001, 1, 0, 0, 0);
    // fourth kind is stored but never takes part
    row(OP_ADD, KIND_UNUSED, 1, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h7fff, 16'h0001, 16'h0000, 1, 0, 0, 0);
    row(OP_CLEAR, KIND_TRIAL, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0);
    row(OP_ADD, KIND_UNUSED, 0, 16'h5555, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h5555, 16'h5555, 16'h5555, 1, 0, 0, 0);
    // include list on the trial number
    row(OP_ADD, KIND_TRIAL, 1, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0);
    row(OP_ADD, KIND_TRIAL, 1, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h0002, 16'h5555, 16'h5555, 1, 0, 0, 0);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h0003, 16'h5555, 16'h5555, 1, 0, 0, 0);
    // fill the table, then two adds that must be dropped
    row(OP_CLEAR, KIND_TRIAL, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, 0, 0);
    row(OP_ADD, KIND_COND, 0, 16'h0007, 16'h0000, 16'h0000, 16'h0000, TABLE_ENTRIES, 1, 0, 0);
    row(OP_ADD, KIND_TRIAL, 1, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 2, 1, 0, 1);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0007, 1, 1, 0, 0);
    row(OP_CHECK, KIND_TRIAL, 0, 16'h0000, 16'h0005, 16'h0005, 16'h0008, 1, 0, 0, 0);

    // --- reset, held at the start and never again ---
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps)
        issue(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
    end
    pause_until_drained();

    // --- random part: mostly clear / load / check sequences, some noise ---
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) pause_until_drained();
      if ($urandom_range(0, 9) == 0) begin
        // noise: any opcode, any kind, any bits
        repeat ($urandom_range(1, 3)) begin
          r = make_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), rand_value(), rand_value(),
                       rand_value(), rand_value());
          drive_checked(r);
        end
      end else begin
        for (int k = 0; k < KIND_COUNT; k++)
          for (int j = 0; j < 4; j++) value_pool[k][j] = pool_value();
        // now and then keep the old table and load on top of it
        if ($urandom_range(0, 3) != 0)
          drive_checked(make_req(OP_CLEAR, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 rand_value(), rand_value(), rand_value(), rand_value()));
        // mostly short lists; rarely a long fill that can run past capacity
        if ($urandom_range(0, 59) == 0) n_add = $urandom_range(240, 270);
        else n_add = $urandom_range(0, 10);
        repeat (n_add) begin
          kind = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
          r = make_req(OP_ADD, kind, 1'($urandom_range(0, 1)),
                       value_pool[(kind == KIND_UNUSED) ? 0 : kind][$urandom_range(0, 3)],
                       rand_value(), rand_value(), rand_value());
          drive_checked(r);
        end
        repeat ($urandom_range(1, 6)) begin
          r = make_req(OP_CHECK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       rand_value(), record_value(0), record_value(1), record_value(2));
          drive_checked(r);
        end
      end
    end

    // --- drain and verdict ---
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_rsp.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_rsp.size()));
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
